// ----- rtl/tpm_pkg.sv -----
// Shared constants, codes and types of the two-level page table manager.
package tpm_pkg;

    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_SLOTS   = 16;
    localparam int TABLE_ENTRIES = 1024;
    localparam int PAGE_SHIFT    = 12;
    localparam int QUEUE_DEPTH   = 2;
    localparam int IDX_W         = 10;
    localparam int FRAME_W       = 20;
    localparam int COUNT_W       = 21;
    localparam int ENTRY_W       = 23;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 21'd1048576;

    localparam logic [1:0] CMD_MAP    = 2'd0;
    localparam logic [1:0] CMD_UNMAP  = 2'd1;
    localparam logic [1:0] CMD_XLATE  = 2'd2;

    localparam logic [1:0] KIND_MAP   = 2'd0;
    localparam logic [1:0] KIND_UNMAP = 2'd1;
    localparam logic [1:0] KIND_XLATE = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_MISS    = 2'd1;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [IDX_W-1:0]    dir_idx;
        logic [IDX_W-1:0]    tbl_idx;
        logic [11:0]         offset;
        logic [FRAME_W-1:0]  frame;
        logic                present;
        logic                writable;
        logic                user;
    } item_t;

endpackage

// ----- rtl/tpm_if.sv -----
// Request and response channel interfaces.
interface tpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic        flag_present;
    logic        flag_writable;
    logic        flag_user;

    modport source (output valid, command, virtual_address, physical_address,
                    flag_present, flag_writable, flag_user, input ready);
    modport sink   (input valid, command, virtual_address, physical_address,
                    flag_present, flag_writable, flag_user, output ready);
endinterface

interface tpm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] translated_address;
    logic        translation_valid;
    logic        invalidate_tlb;
    logic [20:0] mapped_pages;

    modport source (output valid, status, translated_address, translation_valid,
                    invalidate_tlb, mapped_pages, input ready);
    modport sink   (input valid, status, translated_address, translation_valid,
                    invalidate_tlb, mapped_pages, output ready);
endinterface

// ----- rtl/tpm_front.sv -----
// Front end: accepts request transactions and classifies them into queue items.
module tpm_front (
    tpm_req_if.sink        request,
    input  logic           queue_full,
    output logic           push,
    output tpm_pkg::item_t push_item
);

    always_comb
    begin
        push_item.dir_idx  = request.virtual_address[31:22];
        push_item.tbl_idx  = request.virtual_address[21:12];
        push_item.offset   = request.virtual_address[11:0];
        push_item.frame    = request.physical_address[31:12];
        push_item.present  = request.flag_present;
        push_item.writable = request.flag_writable;
        push_item.user     = request.flag_user;
        unique case (request.command)
            tpm_pkg::CMD_MAP:   push_item.kind = tpm_pkg::KIND_MAP;
            tpm_pkg::CMD_UNMAP: push_item.kind = tpm_pkg::KIND_UNMAP;
            tpm_pkg::CMD_XLATE: push_item.kind = tpm_pkg::KIND_XLATE;
            default:            push_item.kind = tpm_pkg::KIND_NOP;
        endcase
    end

    assign request.ready = !queue_full;
    assign push          = request.valid && !queue_full;

endmodule

// ----- rtl/tpm_queue.sv -----
// Short item queue between the front end and the walk engine.
module tpm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tpm_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output tpm_pkg::item_t head_item
);

    localparam int PTR_W = $clog2(tpm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tpm_pkg::QUEUE_DEPTH + 1);

    tpm_pkg::item_t   entry_reg [tpm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(tpm_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tpm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tpm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/tpm_back.sv -----
// Walk engine: directory and table stores, allocation, clearing and results.
module tpm_back #(
    parameter int TABLE_SLOTS = tpm_pkg::TABLE_SLOTS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           write_enable,
    input  logic           write_data,
    input  logic           queue_empty,
    input  tpm_pkg::item_t head_item,
    output logic           pop,
    tpm_rsp_if.source      response
);

    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NF_W    = $clog2(TABLE_SLOTS + 1);
    localparam int DE_W    = SLOT_W + 3;
    localparam int TADDR_W = $clog2(TABLE_SLOTS * tpm_pkg::TABLE_ENTRIES);
    localparam int IDX_W   = tpm_pkg::IDX_W;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIR  = 3'd2;
    localparam logic [2:0] S_CLR  = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_TBL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [DE_W-1:0]    dir_mem [tpm_pkg::DIR_ENTRIES];
    logic [tpm_pkg::ENTRY_W-1:0] tbl_mem [TABLE_SLOTS * tpm_pkg::TABLE_ENTRIES];

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    tpm_pkg::item_t     item_reg, item_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [NF_W-1:0]    free_reg, free_next;
    logic [tpm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic               enable_reg;
    logic [1:0]         res_status_reg, res_status_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_inval_reg, res_inval_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg;
    logic [31:0]        out_addr_reg;
    logic               out_tvalid_reg;
    logic               out_inval_reg;
    logic [tpm_pkg::COUNT_W-1:0] out_count_reg;

    logic [DE_W-1:0]    dir_rdata_reg;
    logic [tpm_pkg::ENTRY_W-1:0] tbl_rdata_reg;
    logic               dir_we;
    logic [IDX_W-1:0]   dir_waddr;
    logic [DE_W-1:0]    dir_wdata;
    logic               tbl_we;
    logic [TADDR_W-1:0] tbl_waddr;
    logic [tpm_pkg::ENTRY_W-1:0] tbl_wdata;
    logic [TADDR_W-1:0] tbl_raddr;
    logic               out_load;

    assign tbl_raddr = TADDR_W'({dir_rdata_reg[DE_W-1:3], item_reg.tbl_idx});
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || response.ready);
    assign pop       = (state_reg == S_IDLE) && !queue_empty;

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        dir_rdata_reg <= dir_mem[head_item.dir_idx];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        item_next       = item_reg;
        slot_next       = slot_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_valid_next  = res_valid_reg;
        res_inval_next  = res_inval_reg;
        dir_we          = 1'b0;
        dir_waddr       = item_reg.dir_idx;
        dir_wdata       = '0;
        tbl_we          = 1'b0;
        tbl_waddr       = TADDR_W'({slot_reg, cnt_reg});
        tbl_wdata       = '0;
        unique case (state_reg)
            S_INIT:
            begin
                dir_we    = 1'b1;
                dir_waddr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(tpm_pkg::DIR_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    item_next       = head_item;
                    res_status_next = tpm_pkg::STATUS_OK;
                    res_addr_next   = '0;
                    res_valid_next  = 1'b0;
                    res_inval_next  = 1'b0;
                    state_next      = S_DIR;
                end
            end
            S_DIR:
            begin
                slot_next = dir_rdata_reg[DE_W-1:3];
                unique case (item_reg.kind) inside
                    tpm_pkg::KIND_MAP:
                    begin
                        if (dir_rdata_reg[0])
                        begin
                            state_next = S_WR;
                        end
                        else if (free_reg == NF_W'(TABLE_SLOTS))
                        begin
                            res_status_next = tpm_pkg::STATUS_NO_SLOT;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            dir_we     = 1'b1;
                            dir_wdata  = {SLOT_W'(free_reg), item_reg.user,
                                          item_reg.writable, 1'b1};
                            slot_next  = SLOT_W'(free_reg);
                            free_next  = free_reg + 1'b1;
                            cnt_next   = '0;
                            state_next = S_CLR;
                        end
                    end
                    tpm_pkg::KIND_UNMAP, tpm_pkg::KIND_XLATE:
                    begin
                        if (item_reg.kind == tpm_pkg::KIND_XLATE && !enable_reg)
                        begin
                            res_addr_next  = {item_reg.dir_idx, item_reg.tbl_idx,
                                              item_reg.offset};
                            res_valid_next = 1'b1;
                            state_next     = S_OUT;
                        end
                        else if (!dir_rdata_reg[0])
                        begin
                            res_status_next = tpm_pkg::STATUS_MISS;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_TBL;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_CLR:
            begin
                tbl_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(tpm_pkg::TABLE_ENTRIES - 1))
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                tbl_we         = 1'b1;
                tbl_waddr      = TADDR_W'({slot_reg, item_reg.tbl_idx});
                tbl_wdata      = {item_reg.frame, item_reg.user, item_reg.writable,
                                  item_reg.present};
                res_inval_next = enable_reg;
                if (count_reg != tpm_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_TBL:
            begin
                tbl_waddr = TADDR_W'({slot_reg, item_reg.tbl_idx});
                if (!tbl_rdata_reg[0])
                begin
                    res_status_next = tpm_pkg::STATUS_MISS;
                end
                else if (item_reg.kind == tpm_pkg::KIND_UNMAP)
                begin
                    tbl_we         = 1'b1;
                    res_inval_next = enable_reg;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                else
                begin
                    res_addr_next  = {tbl_rdata_reg[tpm_pkg::ENTRY_W-1:3], item_reg.offset};
                    res_valid_next = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_valid_reg  <= res_valid_next;
        res_inval_reg  <= res_inval_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_tvalid_reg <= res_valid_reg;
            out_inval_reg  <= res_inval_reg;
            out_count_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (write_enable)
            begin
                enable_reg <= write_data;
            end
        end
    end

    assign response.valid              = out_valid_reg;
    assign response.status             = out_status_reg;
    assign response.translated_address = out_addr_reg;
    assign response.translation_valid  = out_tvalid_reg;
    assign response.invalidate_tlb     = out_inval_reg;
    assign response.mapped_pages       = out_count_reg;

endmodule

// ----- rtl/two_level_page_table_manager_unit.sv -----
// Top level of the two-level page table manager.
// Requests enter a two-entry queue as soon as it has room; the walk engine takes one
// transaction at a time: queue pop, directory read, table read or write, then a result
// register. A map that creates a new table first clears that table through the single
// table store port. After reset the directory is cleared in a pass over all 1024 entries
// before the first item is processed; requests still fill the queue and configuration
// writes are taken during that pass.
module two_level_page_table_manager_unit #(
    parameter int TABLE_SLOTS = tpm_pkg::TABLE_SLOTS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      write_enable,
    input  logic      write_data,
    tpm_req_if.sink   request,
    tpm_rsp_if.source response
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    tpm_pkg::item_t push_item;
    tpm_pkg::item_t head_item;

    tpm_front u_front (
        .request    (request),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    tpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head_item (head_item)
    );

    tpm_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_data   (write_data),
        .queue_empty  (queue_empty),
        .head_item    (head_item),
        .pop          (pop),
        .response     (response)
    );

    assert property (@(posedge clk) disable iff (!rst_n) !(push && queue_full))
        else $error("queue push while full");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && queue_empty))
        else $error("queue pop while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && !response.translation_valid) |-> (response.translated_address == '0))
        else $error("address without valid translation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.invalidate_tlb) |-> (response.status == tpm_pkg::STATUS_OK))
        else $error("invalidate on failed command");

endmodule
